[hdl/simj_pkg.sv]
// Package for the sorted index merge join block: field widths, function and
// configuration codes, and the sequencer state type.
// No dependencies; compile first.
package simj_pkg;

  localparam int FUNC_W     = 2;
  localparam int POS_W      = 10;
  localparam int IDX_W      = 31;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 11;
  localparam int LEN_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // function codes carried by each input item
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MERGE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LENGTH = 1'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_RESULT
  } state_t;

endpackage

[hdl/simj_in_if.sv]
// Input channel of the merge join block: valid/ready handshake plus item fields.
// Depends on simj_pkg.
interface simj_in_if import simj_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [POS_W-1:0]        position;
  logic [IDX_W-1:0]        pixel_index;
  logic signed [VAL_W-1:0] pixel_value;
  logic                    last_of_pass;

  modport source (output valid, func, position, pixel_index, pixel_value, last_of_pass,
                  input ready);
  modport sink   (input valid, func, position, pixel_index, pixel_value, last_of_pass,
                  output ready);
endinterface

[hdl/simj_out_if.sv]
// Result channel of the merge join block: valid/ready handshake plus result fields.
// Depends on simj_pkg.
interface simj_out_if import simj_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    matched;
  logic [CNT_W-1:0]        match_count;
  logic [IDX_W-1:0]        read_index;
  logic signed [VAL_W-1:0] read_value;

  modport source (output valid, matched, match_count, read_index, read_value,
                  input ready);
  modport sink   (input valid, matched, match_count, read_index, read_value,
                  output ready);
endinterface

[hdl/simj_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependency.
module simj_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/sorted_index_merge_join.sv]
// Channel   Dir  Handshake        Payload
// in_if     in   valid/ready      func, position, pixel_index, pixel_value, last_of_pass
// out_if    out  valid/ready      matched, match_count, read_index, read_value
// cfg_*     in   write enable     cfg_index, cfg_wdata (merge_mode, second_length)
//
// One item at a time: a load writes both RAMs, a read fetches one entry, and
// a merge steps the scan pointer past smaller stored indexes (one index RAM
// read per step) until it meets an equal or larger index or the configured
// length; an exhausted pass goes straight to the result state. A matched entry
// is read, updated and written back before the next item is taken. Reset
// (synchronous, rst_n low) clears the scan pointer, match counter, registers
// and output valid; RAM contents stay undefined until loaded. A stalled result
// holds in the output register; the next item then waits in the result state
// with input ready low until the output register frees.
// Depends on simj_pkg, simj_in_if, simj_out_if and simj_ram.
module sorted_index_merge_join import simj_pkg::*; #(
  parameter int MAP_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  simj_in_if.sink               in_if,
  simj_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW     = $clog2(MAP_DEPTH);
  localparam int PTR_W  = $clog2(MAP_DEPTH + 1);
  localparam int POS_XW = (AW > POS_W) ? AW : POS_W;

  state_t state_r, state_nxt;

  // latched item
  logic [FUNC_W-1:0]       func_r;
  logic [POS_W-1:0]        pos_r;
  logic [IDX_W-1:0]        key_r;
  logic signed [VAL_W-1:0] val_r;
  logic                    last_r;

  // scan state and configuration
  logic [PTR_W-1:0] ptr_r, ptr_nxt, ptr_inc;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             mode_r;
  logic [LEN_W-1:0] len_r;
  logic [PTR_W-1:0] eff_len;

  // result staging
  logic                    hit_r, hit_nxt;
  logic [IDX_W-1:0]        ridx_r, ridx_nxt;
  logic signed [VAL_W-1:0] rval_r, rval_nxt;

  // output register
  logic                    out_valid_r;
  logic                    out_matched_r;
  logic [CNT_W-1:0]        out_count_r;
  logic [IDX_W-1:0]        out_index_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic                    out_load;

  // RAM ports
  logic [AW-1:0]    ram_raddr, ram_waddr;
  logic             idx_we, val_we;
  logic [IDX_W-1:0] idx_wdata, idx_rd;
  logic [VAL_W-1:0] val_wdata, val_rd;

  logic              in_fire;
  logic              pos_ok_in, pos_ok_r;
  logic [POS_XW-1:0] pos_in_ext;
  logic [VAL_W-1:0]  merged_val;

  simj_ram #(.WIDTH(IDX_W), .DEPTH(MAP_DEPTH)) u_idx_ram (
    .clk   (clk),
    .we    (idx_we),
    .waddr (ram_waddr),
    .wdata (idx_wdata),
    .raddr (ram_raddr),
    .rdata (idx_rd)
  );

  simj_ram #(.WIDTH(VAL_W), .DEPTH(MAP_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (ram_waddr),
    .wdata (val_wdata),
    .raddr (ram_raddr),
    .rdata (val_rd)
  );

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;

  // clamp the configured length to the map depth
  always_comb begin
    if (32'(len_r) > 32'(MAP_DEPTH)) begin
      eff_len = PTR_W'(MAP_DEPTH);
    end else begin
      eff_len = PTR_W'(len_r);
    end
  end

  assign pos_ok_in  = 32'(in_if.position) < 32'(MAP_DEPTH);
  assign pos_ok_r   = 32'(pos_r) < 32'(MAP_DEPTH);
  assign pos_in_ext = POS_XW'(in_if.position);
  assign ptr_inc    = ptr_r + 1'b1;
  assign merged_val = mode_r ? (val_rd + val_r) : val_r;

  // sequencer: next state, RAM access and result staging
  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    hit_nxt   = hit_r;
    ridx_nxt  = ridx_r;
    rval_nxt  = rval_r;
    ram_raddr = ptr_r[AW-1:0];
    ram_waddr = ptr_r[AW-1:0];
    idx_we    = 1'b0;
    val_we    = 1'b0;
    idx_wdata = in_if.pixel_index;
    val_wdata = in_if.pixel_value;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          hit_nxt  = 1'b0;
          ridx_nxt = '0;
          rval_nxt = '0;
          unique case (in_if.func)
            FUNC_LOAD: begin
              idx_we    = pos_ok_in;
              val_we    = pos_ok_in;
              ram_waddr = pos_in_ext[AW-1:0];
              state_nxt = S_RESULT;
            end
            FUNC_MERGE: begin
              ram_raddr = ptr_r[AW-1:0];
              state_nxt = (ptr_r < eff_len) ? S_SCAN : S_RESULT;
            end
            FUNC_READ: begin
              ram_raddr = pos_in_ext[AW-1:0];
              state_nxt = S_READ;
            end
            default: begin
              state_nxt = S_RESULT;
            end
          endcase
        end
      end
      S_READ: begin
        if (pos_ok_r) begin
          ridx_nxt = idx_rd;
          rval_nxt = val_rd;
        end
        state_nxt = S_RESULT;
      end
      S_SCAN: begin
        if (idx_rd < key_r) begin
          // advance past a smaller stored index
          ptr_nxt   = ptr_inc;
          ram_raddr = ptr_inc[AW-1:0];
          state_nxt = (ptr_inc < eff_len) ? S_SCAN : S_RESULT;
        end else if (idx_rd == key_r) begin
          // update the matched entry and write it back
          val_we    = 1'b1;
          ram_waddr = ptr_r[AW-1:0];
          val_wdata = merged_val;
          cnt_nxt   = cnt_r + 1'b1;
          ptr_nxt   = ptr_inc;
          hit_nxt   = 1'b1;
          ridx_nxt  = idx_rd;
          rval_nxt  = merged_val;
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          // end of pass: rewind pointer and counter after reporting
          if (func_r == FUNC_MERGE && last_r) begin
            ptr_nxt = '0;
            cnt_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      cnt_r       <= '0;
      mode_r      <= 1'b0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MERGE_MODE:    mode_r <= cfg_wdata[0];
          CFG_SECOND_LENGTH: len_r  <= cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the accepted item and the staged result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_if.func;
      pos_r  <= in_if.position;
      key_r  <= in_if.pixel_index;
      val_r  <= in_if.pixel_value;
      last_r <= in_if.last_of_pass;
    end
    hit_r  <= hit_nxt;
    ridx_r <= ridx_nxt;
    rval_r <= rval_nxt;
  end

  // output register: one transfer per item
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_matched_r <= hit_r;
      out_count_r   <= cnt_r;
      out_index_r   <= ridx_r;
      out_value_r   <= rval_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.matched     = out_matched_r;
  assign out_if.match_count = out_count_r;
  assign out_if.read_index  = out_index_r;
  assign out_if.read_value  = out_value_r;

`ifndef SYNTHESIS
  // a match moves the pointer and the counter on by exactly one
  a_match_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && val_we) |=>
      (ptr_r == $past(ptr_r) + 1'b1 && cnt_r == $past(cnt_r) + 1'b1))
    else $error("match did not advance pointer and counter by one");

  // a new result appears only from the result state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RESULT)
    else $error("output valid rose outside the result state");

  // value RAM is written only by a load transfer or a match write-back
  a_val_write: assert property (@(posedge clk) disable iff (!rst_n)
    val_we |-> ((state_r == S_IDLE && in_fire && in_if.func == FUNC_LOAD) ||
                state_r == S_SCAN))
    else $error("unexpected value RAM write");
`endif

endmodule
